// ===== rtl/tfr_pkg.sv =====
// Package for the tagged frame receiver: byte type, tag codes, register
// indexes, reset marks and the slot control struct.
// No dependencies.
`default_nettype none

package tfr_pkg;

  typedef logic [7:0] tfr_byte_t;

  localparam int FRAME_BYTES_DEF = 14;
  localparam int CFG_INDEX_W     = 8;
  localparam int VALUE_W         = 16;
  localparam int SLOTS           = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_START_MARK = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_END_MARK   = CFG_INDEX_W'(1);

  localparam tfr_byte_t START_MARK_RST = 8'hd8;
  localparam tfr_byte_t END_MARK_RST   = 8'hee;

  localparam tfr_byte_t TAG_LEFT    = 8'hb0;
  localparam tfr_byte_t TAG_RIGHT   = 8'hb1;
  localparam tfr_byte_t TAG_ERROR   = 8'hb2;
  localparam tfr_byte_t TAG_CONTROL = 8'hb3;

  localparam tfr_byte_t SLOT_TAGS [SLOTS] = '{TAG_LEFT, TAG_RIGHT, TAG_ERROR, TAG_CONTROL};

  typedef struct packed {
    logic      load;
    tfr_byte_t want;
    tfr_byte_t tag;
    tfr_byte_t hi;
    tfr_byte_t lo;
  } tfr_slot_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/tagged_frame_receiver.sv =====
// Tagged frame receiver: the result is registered on byte accept; one byte per cycle
// while the output is taken; the output register frees in the cycle its result is taken.
// Bytes shift through a chain of FRAME_BYTES-2 cells; tags are read at fixed cells.
// Reset clears the frame position, the held values and the output register, and
// restores the start and end marks; the byte chain is not reset.
// Depends on tfr_pkg, tfr_cell, tfr_slot.
`default_nettype none

module tagged_frame_receiver #(
  parameter int FRAME_BYTES = tfr_pkg::FRAME_BYTES_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [7:0]                         in_tdata,   // rx_byte[7:0]
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [4*tfr_pkg::VALUE_W-1:0]      out_tdata,  // left_count, right_count,
                                                         // error_value, control_value
  output logic                               out_tuser,  // frame_done
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [tfr_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [7:0]                         cfg_data
);

  localparam int PW    = $clog2(FRAME_BYTES);
  localparam int CHAIN = FRAME_BYTES - 2;

  tfr_pkg::tfr_byte_t start_mark_r, start_mark_nxt;
  tfr_pkg::tfr_byte_t end_mark_r, end_mark_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               done_r, done_nxt;

  logic take, store, last, commit;

  tfr_pkg::tfr_byte_t chain_q [CHAIN];
  tfr_pkg::tfr_slot_ctl_t slot_ctl [tfr_pkg::SLOTS];
  logic [tfr_pkg::VALUE_W-1:0] held [tfr_pkg::SLOTS];

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;

  assign take   = in_tvalid && in_tready;
  assign store  = take && ((pos_r != '0) || (in_tdata == start_mark_r));
  assign last   = (pos_r == PW'(FRAME_BYTES - 1));
  assign commit = store && last && (in_tdata == end_mark_r);

  always_comb begin
    start_mark_nxt = start_mark_r;
    end_mark_nxt   = end_mark_r;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == tfr_pkg::REG_START_MARK) begin
        start_mark_nxt = cfg_data;
      end else if (cfg_index == tfr_pkg::REG_END_MARK) begin
        end_mark_nxt = cfg_data;
      end
    end

    pos_nxt = pos_r;
    if (store) begin
      pos_nxt = last ? '0 : pos_r + PW'(1);
    end

    out_valid_nxt = out_valid_r;
    done_nxt      = done_r;
    if (take) begin
      out_valid_nxt = 1'b1;
      done_nxt      = commit;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_mark_r <= tfr_pkg::START_MARK_RST;
      end_mark_r   <= tfr_pkg::END_MARK_RST;
      pos_r        <= '0;
      out_valid_r  <= 1'b0;
      done_r       <= 1'b0;
    end else begin
      start_mark_r <= start_mark_nxt;
      end_mark_r   <= end_mark_nxt;
      pos_r        <= pos_nxt;
      out_valid_r  <= out_valid_nxt;
      done_r       <= done_nxt;
    end
  end

  for (genvar i = 0; i < CHAIN; i++) begin : g_cell
    if (i == 0) begin : g_head
      tfr_cell u_cell (
        .clk  (clk),
        .shift(store),
        .din  (in_tdata),
        .dout (chain_q[i])
      );
    end else begin : g_body
      tfr_cell u_cell (
        .clk  (clk),
        .shift(store),
        .din  (chain_q[i-1]),
        .dout (chain_q[i])
      );
    end
  end

  // frame byte k sits in cell FRAME_BYTES-2-k when the closing byte arrives
  for (genvar j = 0; j < tfr_pkg::SLOTS; j++) begin : g_slot
    localparam int TAG_CELL = FRAME_BYTES - 3 - 3 * j;

    assign slot_ctl[j] = '{
      load: commit,
      want: tfr_pkg::SLOT_TAGS[j],
      tag:  chain_q[TAG_CELL],
      hi:   chain_q[TAG_CELL-1],
      lo:   chain_q[TAG_CELL-2]
    };

    tfr_slot u_slot (
      .clk  (clk),
      .rst_n(rst_n),
      .ctl  (slot_ctl[j]),
      .held (held[j])
    );

    assign out_tdata[j*tfr_pkg::VALUE_W +: tfr_pkg::VALUE_W] = held[j];
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = done_r;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= PW'(FRAME_BYTES - 1))
    else $error("frame position out of range");

  a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_tvalid && out_tuser)
    else $error("committed frame not reported");

  a_held_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !commit |=> $stable(out_tdata))
    else $error("held values changed without a committed frame");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    take && (pos_r != PW'(FRAME_BYTES - 1)) |=> !out_tuser)
    else $error("frame done outside the closing byte");
`endif

endmodule

`default_nettype wire

// ===== rtl/tfr_cell.sv =====
// One byte cell of the frame shift chain.
// Depends on tfr_pkg.
`default_nettype none

module tfr_cell (
  input  wire               clk,
  input  wire               shift,
  input  tfr_pkg::tfr_byte_t din,
  output tfr_pkg::tfr_byte_t dout
);

  tfr_pkg::tfr_byte_t data_r;
  tfr_pkg::tfr_byte_t data_nxt;

  always_comb begin
    data_nxt = shift ? din : data_r;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign dout = data_r;

endmodule

`default_nettype wire

// ===== rtl/tfr_slot.sv =====
// Held value slot: loads a big-endian value when its tag matches on commit.
// Depends on tfr_pkg.
`default_nettype none

module tfr_slot (
  input  wire                           clk,
  input  wire                           rst_n,
  input  tfr_pkg::tfr_slot_ctl_t        ctl,
  output logic [tfr_pkg::VALUE_W-1:0]   held
);

  logic [tfr_pkg::VALUE_W-1:0] held_r;
  logic [tfr_pkg::VALUE_W-1:0] held_nxt;

  always_comb begin
    held_nxt = held_r;
    if (ctl.load && (ctl.tag == ctl.want)) begin
      held_nxt = {ctl.hi, ctl.lo};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
    end else begin
      held_r <= held_nxt;
    end
  end

  assign held = held_r;

endmodule

`default_nettype wire

// ===== sim/tb_tagged_frame_receiver.sv =====
`timescale 1ns / 100ps
// Testbench for tagged_frame_receiver: streams received bytes and mark register
// writes, predicts every readout of the held values and checks it field by field.
// Depends on tfr_pkg and the receiver RTL.
module tb_tagged_frame_receiver;

  localparam int FRAME_LEN   = tfr_pkg::FRAME_BYTES_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 6;
  localparam int PHASE_BYTES = 325;
  localparam int REPORT_MAX  = 10;
  localparam int HOLD_CYCLES = 300;
  localparam int DIR_ROWS    = 29;

  typedef struct packed {
    logic                                            done;
    logic [tfr_pkg::SLOTS-1:0][tfr_pkg::VALUE_W-1:0] vals;
  } readout_t;

  typedef struct {
    tfr_pkg::tfr_byte_t rx;
    bit                 typed;
    readout_t           want;
  } dir_row_t;

  localparam readout_t NONE    = '0;
  localparam readout_t FRAME_A = {1'b1, 16'hd800, 16'hffff, 16'h8000, 16'h7fff};
  localparam readout_t HOLD_A  = {1'b0, 16'hd800, 16'hffff, 16'h8000, 16'h7fff};

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [4*tfr_pkg::VALUE_W-1:0]   out_tdata;
  logic                            out_tuser;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [tfr_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [7:0]                      cfg_data   = '0;

  tagged_frame_receiver #(.FRAME_BYTES(FRAME_LEN)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // receiver state mirror
  tfr_pkg::tfr_byte_t start_mark_q = tfr_pkg::START_MARK_RST;
  tfr_pkg::tfr_byte_t end_mark_q   = tfr_pkg::END_MARK_RST;
  int                 frame_pos    = 0;
  tfr_pkg::tfr_byte_t frame_buf [FRAME_LEN];
  logic [tfr_pkg::SLOTS-1:0][tfr_pkg::VALUE_W-1:0] held_vals = '0;

  readout_t readout_q [$];
  bit       calm     = 1'b0;
  bit       hold_req = 1'b0;
  int       fails    = 0;
  int       bytes_sent   = 0;
  int       results_seen = 0;
  int       frames_done  = 0;
  int       cfg_writes   = 0;
  int       cycle_count  = 0;

  string slot_name [tfr_pkg::SLOTS] =
    '{"left_count", "right_count", "error_value", "control_value"};

  dir_row_t dir_tab [DIR_ROWS] = '{
    '{8'hff, 1'b1, NONE},
    '{8'hd8, 1'b1, NONE}, '{8'hb0, 1'b1, NONE}, '{8'h7f, 1'b1, NONE},
    '{8'hff, 1'b1, NONE}, '{8'hb1, 1'b1, NONE}, '{8'h80, 1'b1, NONE},
    '{8'h00, 1'b1, NONE}, '{8'hb2, 1'b1, NONE}, '{8'hff, 1'b1, NONE},
    '{8'hff, 1'b1, NONE}, '{8'hb3, 1'b1, NONE}, '{8'hd8, 1'b1, NONE},
    '{8'h00, 1'b1, NONE}, '{8'hee, 1'b1, FRAME_A},
    '{8'hd8, 1'b1, HOLD_A}, '{8'hb0, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
    '{8'h00, 1'b0, NONE}, '{8'hb1, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
    '{8'h00, 1'b0, NONE}, '{8'hb2, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
    '{8'h00, 1'b0, NONE}, '{8'hb3, 1'b0, NONE}, '{8'h00, 1'b0, NONE},
    '{8'h00, 1'b0, NONE}, '{8'hed, 1'b1, HOLD_A}
  };

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic readout_t receive_byte(input tfr_pkg::tfr_byte_t b);
    readout_t r;
    r.done = 1'b0;
    if (frame_pos != 0 || b == start_mark_q) begin
      frame_buf[frame_pos] = b;
      frame_pos++;
      if (frame_pos == FRAME_LEN) begin
        frame_pos = 0;
        if (b == end_mark_q) begin
          for (int s = 0; s < tfr_pkg::SLOTS; s++) begin
            if (frame_buf[1 + 3*s] == tfr_pkg::SLOT_TAGS[s])
              held_vals[s] = {frame_buf[2 + 3*s], frame_buf[3 + 3*s]};
          end
          r.done = 1'b1;
        end
      end
    end
    r.vals = held_vals;
    return r;
  endfunction

  task automatic push_byte(input tfr_pkg::tfr_byte_t b, input bit typed,
                           input readout_t want);
    readout_t model;
    if (!calm) begin
      while ($urandom_range(99) < 15) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    model = receive_byte(b);
    readout_q.push_back(typed ? want : model);
    bytes_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tfr_pkg::CFG_INDEX_W-1:0] idx,
                           input tfr_pkg::tfr_byte_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == tfr_pkg::REG_START_MARK)
      start_mark_q = val;
    else if (idx == tfr_pkg::REG_END_MARK)
      end_mark_q = val;
    cfg_writes++;
  endtask

  task automatic set_marks(input tfr_pkg::tfr_byte_t s, input tfr_pkg::tfr_byte_t e,
                           input bit stray);
    write_reg(tfr_pkg::REG_START_MARK, s);
    write_reg(tfr_pkg::REG_END_MARK, e);
    if (stray)
      write_reg(tfr_pkg::REG_END_MARK +
                tfr_pkg::CFG_INDEX_W'($urandom_range(1, 254)),
                tfr_pkg::tfr_byte_t'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic tfr_pkg::tfr_byte_t body_byte(input int i);
    tfr_pkg::tfr_byte_t edges [4] = '{8'h00, 8'hff, 8'h7f, 8'h80};
    if (i % 3 == 0)
      return ($urandom_range(99) < 75) ? tfr_pkg::SLOT_TAGS[i / 3]
                                       : tfr_pkg::tfr_byte_t'($urandom);
    if ($urandom_range(99) < 20)
      return edges[$urandom_range(3)];
    return tfr_pkg::tfr_byte_t'($urandom);
  endfunction

  // tidy: full frame; otherwise a cut-short frame that the next start misaligns
  task automatic send_frame(input bit tidy);
    int body;
    tfr_pkg::tfr_byte_t close;
    body = tidy ? FRAME_LEN - 2 : $urandom_range(FRAME_LEN - 2);
    push_byte(start_mark_q, 1'b0, NONE);
    for (int i = 0; i < body; i++)
      push_byte(body_byte(i), 1'b0, NONE);
    if (tidy) begin
      close = ($urandom_range(9) < 8) ? end_mark_q : tfr_pkg::tfr_byte_t'($urandom);
      push_byte(close, 1'b0, NONE);
    end
  endtask

  task automatic report_miss(input string what, input logic [tfr_pkg::VALUE_W-1:0] want,
                             input logic [tfr_pkg::VALUE_W-1:0] got);
    fails++;
    if (fails <= REPORT_MAX)
      $display("mismatch %0d at %0t: %s expected %h got %h", fails, $time, what, want, got);
  endtask

  always @(posedge clk) begin
    readout_t want;
    readout_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser, out_tdata};
      results_seen++;
      if (got.done === 1'b1)
        frames_done++;
      if (readout_q.size() == 0) begin
        report_miss("readout with no request pending, frame_done", '0,
                    tfr_pkg::VALUE_W'(got.done));
      end else begin
        want = readout_q.pop_front();
        if (got.done !== want.done)
          report_miss("frame_done", tfr_pkg::VALUE_W'(want.done),
                      tfr_pkg::VALUE_W'(got.done));
        for (int s = 0; s < tfr_pkg::SLOTS; s++) begin
          if (got.vals[s] !== want.vals[s])
            report_miss(slot_name[s], want.vals[s], got.vals[s]);
        end
      end
    end
  end

  // hold off for a long stretch on request, else always ready when calm, else stall at random
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_cnt = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 15);
      end
    end
  end

  initial begin
    int phase_start;
    int pick;
    bit held_once;
    bit paused_once;
    held_once   = 1'b0;
    paused_once = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      push_byte(dir_tab[r].rx, dir_tab[r].typed, dir_tab[r].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case (phase)
        1: set_marks(8'h00, 8'hff, 1'b0);
        2: set_marks(8'hff, 8'h00, 1'b0);
        3: set_marks(tfr_pkg::tfr_byte_t'($urandom), tfr_pkg::tfr_byte_t'($urandom), 1'b1);
        4: set_marks(8'h5a, 8'h5a, 1'b0);
        5: set_marks(tfr_pkg::START_MARK_RST, tfr_pkg::END_MARK_RST, 1'b0);
        default: ;
      endcase
      calm = (phase == 2);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        pick = $urandom_range(99);
        if (pick < 70) begin
          send_frame(1'b1);
        end else if (pick < 85) begin
          send_frame(1'b0);
        end else begin
          repeat ($urandom_range(1, 4)) push_byte(tfr_pkg::tfr_byte_t'($urandom), 1'b0, NONE);
        end
        if (phase == 1 && !held_once && bytes_sent - phase_start > 100) begin
          hold_req  = 1'b1;
          held_once = 1'b1;
        end
        if (phase == 3 && !paused_once && bytes_sent - phase_start > 150) begin
          drain();
          paused_once = 1'b1;
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    $display("covered %0d bytes over %0d mark settings with %0d register writes",
             bytes_sent, PHASES, cfg_writes);
    $display("checked %0d readouts, %0d closed frames, %0d mismatches",
             results_seen, frames_done, fails);
    if (fails == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
